FILE: rtl/pgjm_pkg.sv
// ---------------------------------------------------------------------------
// pgjm_pkg: shared types and constants of the pitch glide / jitter modulator
// Payload structs, register indexes and fixed-point constants.
// ---------------------------------------------------------------------------
package pgjm_pkg;

  localparam int STRING_COUNT_DEF    = 6;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // register indexes
  localparam logic [2:0] REG_MULT   = 3'd0;
  localparam logic [2:0] REG_GLIDE  = 3'd1;
  localparam logic [2:0] REG_JITTER = 3'd2;
  localparam logic [2:0] REG_MASK   = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;

  localparam logic [15:0] GLIDE_MAX  = 16'd51200;
  localparam logic [14:0] JITTER_MAX = 15'd20480;
  localparam logic [15:0] DYN_ONE    = 16'd32768;
  localparam logic [23:0] FREQ_MAX   = 24'hFFFFFF;
  localparam logic [31:0] ONE_Q30    = 32'd1073741824;
  localparam logic [31:0] LN2_K      = 32'd39693926;
  localparam logic [16:0] POLY_A     = 17'd102944;
  localparam logic [15:0] POLY_B     = 16'd42334;
  localparam logic [31:0] POLY_C     = 32'd5209;
  localparam logic [3:0]  DIV_NOISE  = 4'd15;
  localparam logic [3:0]  DIV_CUBE   = 4'd6;

  // sqrt(1), sqrt(2), sqrt(3) and sqrt(5) in Q30 for the four noise phase steps
  localparam logic [31:0] RATIO_Q30 [4] = '{
    32'd1073741824, 32'd1518500250, 32'd1859775393, 32'd2400959708
  };

  typedef struct packed {
    logic        action;
    logic [23:0] pitch_hz;
    logic [15:0] dynamics;
    logic        tail_mode;
  } in_item_t;

  typedef struct packed {
    logic [23:0] freq_hz;
    logic [15:0] gain;
    logic [5:0]  gate_mask;
  } out_item_t;

endpackage

FILE: rtl/pgjm_mul.sv
// ---------------------------------------------------------------------------
// pgjm_mul: bit-serial 32x32 unsigned multiplier
// One multiplier bit per cycle, 64-bit product.
// ---------------------------------------------------------------------------
module pgjm_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod,
  output logic        done
);

  logic [63:0] acc_r;
  logic [31:0] a_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] part;

  // add the multiplicand into the upper half when the low bit is set
  assign part = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, a_r} : 33'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {32'd0, b};
      a_r   <= a;
    end else if (busy_r) begin
      acc_r <= {part, acc_r[31:1]};
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

FILE: rtl/pgjm_div.sv
// ---------------------------------------------------------------------------
// pgjm_div: bit-serial restoring divider by a small divisor
// One quotient bit per cycle, divisor up to 15.
// ---------------------------------------------------------------------------
module pgjm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [3:0]  divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic [31:0] q_r;
  logic [3:0]  rem_r;
  logic [3:0]  dv_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [4:0]  trial;
  logic        fit;

  assign trial = {rem_r, q_r[31]};
  assign fit   = trial >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift one dividend bit in, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= fit ? 4'(trial - {1'b0, dv_r}) : trial[3:0];
      q_r   <= {q_r[30:0], fit};
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

FILE: rtl/pitch_glide_jitter_modulator.sv
// ---------------------------------------------------------------------------
// pitch_glide_jitter_modulator: per-sample pitch glide and jitter
// Sequencer around one bit-serial multiplier and one serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request per audio sample:
//   action 0 computes a sample, action 1 restarts (clears the noise phases,
//   no result). Output channel out_valid/out_ready returns freq_hz, gain
//   and gate_mask. Registers are to be written through
//   cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block
//   itself does not enforce this. Unknown indexes are ignored. A compute
//   request runs 29 multiplies and 2 divides on the shared serial units,
//   each one issued from ST_ISSUE and waited for in ST_MUL or ST_DIV until
//   done; ST_OUT then loads the output register. A restart is handled in
//   ST_IDLE on accept. One request is in flight at a time; the serial
//   multiplier sets the rate.
// Reset:
//   rst_n restores register defaults and clears the four noise phases.
// Stall:
//   A finished result sits in the output register; the next request can be
//   accepted meanwhile, and its own result waits until that one is taken.
// ---------------------------------------------------------------------------
module pitch_glide_jitter_modulator #(
  parameter int STRING_COUNT    = pgjm_pkg::STRING_COUNT_DEF,
  parameter int SINE_TABLE_BITS = pgjm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pgjm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pgjm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    OP_T2, OP_U, OP_V, OP_S, OP_PH, OP_NS, OP_D2, OP_GL,
    OP_JM, OP_JT, OP_Y, OP_Y2, OP_Y3, OP_E, OP_PM, OP_F
  } op_t;

  localparam int TSH = 18 - SINE_TABLE_BITS;

  state_t state_r;
  op_t    op_r;
  logic [1:0] k_r;

  // configuration registers
  logic [15:0] mult_r, glide_amt_r;
  logic [14:0] jitter_amt_r;
  logic [5:0]  mask_r;
  logic [31:0] step_r;
  logic [31:0] phase_r [4];

  // latched request
  logic [23:0] pitch_r;
  logic [15:0] dyn_r, d_r;
  logic        tail_r;

  // working registers
  logic [16:0] t_r, t2_r, v_r;
  logic [15:0] u_r;
  logic [1:0]  quad_r;
  logic signed [19:0] sum_r;
  logic signed [15:0] noise_r;
  logic [15:0] d2_r, glide_r;
  logic [14:0] jm_r;
  logic signed [17:0] cents_r;
  logic [26:0] ym_r, y2_r;
  logic        ysgn_r;
  logic [31:0] y3m_r, e_r;
  logic [27:0] pm_r;
  logic [23:0] freq_r;

  logic        out_valid_r;
  pgjm_pkg::out_item_t out_r;

  logic        accept;
  logic        mul_start, div_start, mul_done, div_done;
  logic [31:0] mul_a, mul_b, div_n, quo;
  logic [3:0]  div_d;
  logic [63:0] prod;

  // sine argument from the current phase
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]  quad;
  logic [16:0] t0, t_cur;
  assign idx   = phase_r[k_r][31 -: SINE_TABLE_BITS];
  assign quad  = idx[SINE_TABLE_BITS-1 -: 2];
  assign t0    = 17'(idx[SINE_TABLE_BITS-3:0]) << TSH;
  assign t_cur = quad[0] ? (17'd65536 - t0) : t0;

  // magnitudes
  logic [19:0] sum_mag;
  logic [17:0] cents_mag;
  logic [15:0] noise_mag;
  assign sum_mag   = sum_r[19] ? 20'(-sum_r) : 20'(sum_r);
  assign cents_mag = cents_r[17] ? 18'(-cents_r) : 18'(cents_r);
  assign noise_mag = noise_r[15] ? 16'(-noise_r) : 16'(noise_r);

  // clamped amounts
  logic [15:0] g_cl;
  logic [14:0] j_cl;
  assign g_cl = (glide_amt_r > pgjm_pkg::GLIDE_MAX) ? pgjm_pkg::GLIDE_MAX : glide_amt_r;
  assign j_cl = (jitter_amt_r > pgjm_pkg::JITTER_MAX) ? pgjm_pkg::JITTER_MAX : jitter_amt_r;

  // sine result from the last product
  logic [31:0] s_a;
  logic [15:0] s_b;
  logic [14:0] s_mag;
  logic signed [19:0] s_term;
  assign s_a    = (prod[47:16] > 32'd65536) ? 32'd65536 : prod[47:16];
  assign s_b    = s_a[16:1];
  assign s_mag  = (s_b > 16'd32767) ? 15'h7FFF : s_b[14:0];
  assign s_term = (quad_r[1] ? -20'(s_mag) : 20'(s_mag)) <<< (2'd3 - k_r);

  // exponential sum
  logic signed [32:0] e_sum;
  logic [26:0] q_y3;
  assign q_y3  = quo[26:0];
  assign e_sum = 33'(pgjm_pkg::ONE_Q30)
               + (ysgn_r ? -33'(ym_r) : 33'(ym_r))
               + 33'(y2_r >> 1)
               + (ysgn_r ? -33'(q_y3) : 33'(q_y3));

  // jitter and cents
  logic [14:0] jitm;
  assign jitm = prod[29:15];

  // gates
  logic [5:0] gate_en;
  always_comb begin
    for (int i = 0; i < 6; i++) gate_en[i] = (i < STRING_COUNT);
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // operand selection for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = pgjm_pkg::DIV_NOISE;
    case (op_r)
      OP_T2: begin mul_a = 32'(t_cur); mul_b = 32'(t_cur); end
      OP_U:  begin mul_a = pgjm_pkg::POLY_C; mul_b = 32'(t2_r); end
      OP_V:  begin mul_a = 32'(t2_r); mul_b = 32'(u_r); end
      OP_S:  begin mul_a = 32'(t_r); mul_b = 32'(v_r); end
      OP_PH: begin mul_a = step_r; mul_b = pgjm_pkg::RATIO_Q30[k_r]; end
      OP_NS: begin div_n = 32'(sum_mag); div_d = pgjm_pkg::DIV_NOISE; end
      OP_D2: begin mul_a = 32'(d_r); mul_b = 32'(d_r); end
      OP_GL: begin mul_a = 32'(g_cl); mul_b = 32'(d2_r); end
      OP_JM: begin mul_a = 32'(j_cl); mul_b = 32'(d_r); end
      OP_JT: begin mul_a = 32'(jm_r); mul_b = 32'(noise_mag); end
      OP_Y:  begin mul_a = 32'(cents_mag); mul_b = pgjm_pkg::LN2_K; end
      OP_Y2: begin mul_a = 32'(ym_r); mul_b = 32'(ym_r); end
      OP_Y3: begin mul_a = 32'(y2_r); mul_b = 32'(ym_r); end
      OP_E:  begin div_n = y3m_r; div_d = pgjm_pkg::DIV_CUBE; end
      OP_PM: begin mul_a = 32'(pitch_r); mul_b = 32'(mult_r); end
      OP_F:  begin mul_a = 32'(pm_r); mul_b = e_r; end
      default: ;
    endcase
  end

  assign mul_start = (state_r == ST_ISSUE) && !(op_r == OP_NS || op_r == OP_E);
  assign div_start = (state_r == ST_ISSUE) && (op_r == OP_NS || op_r == OP_E);

  pgjm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(prod), .done(mul_done)
  );

  pgjm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
    .quotient(quo), .done(div_done)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r       <= 16'd4096;
      glide_amt_r  <= '0;
      jitter_amt_r <= '0;
      mask_r       <= 6'h3F;
      step_r       <= 32'd268435;
    end else if (cfg_we) begin
      case (cfg_addr)
        pgjm_pkg::REG_MULT:   mult_r       <= cfg_wdata[15:0];
        pgjm_pkg::REG_GLIDE:  glide_amt_r  <= cfg_wdata[15:0];
        pgjm_pkg::REG_JITTER: jitter_amt_r <= cfg_wdata[14:0];
        pgjm_pkg::REG_MASK:   mask_r       <= cfg_wdata[5:0];
        pgjm_pkg::REG_STEP:   step_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_T2;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) phase_r[i] <= '0;
    end else begin
      // output register: load from ST_OUT, clear once taken
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.action) begin
              for (int i = 0; i < 4; i++) phase_r[i] <= '0;
            end else begin
              state_r <= ST_ISSUE;
              op_r    <= OP_T2;
              k_r     <= '0;
            end
          end
        end
        ST_ISSUE: begin
          state_r <= (op_r == OP_NS || op_r == OP_E) ? ST_DIV : ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            state_r <= (op_r == OP_F) ? ST_OUT : ST_ISSUE;
            case (op_r)
              OP_T2: op_r <= OP_U;
              OP_U:  op_r <= OP_V;
              OP_V:  op_r <= OP_S;
              OP_S: begin
                k_r  <= k_r + 2'd1;
                op_r <= (k_r == 2'd3) ? OP_PH : OP_T2;
              end
              OP_PH: begin
                phase_r[k_r] <= phase_r[k_r] + prod[61:30];
                k_r  <= k_r + 2'd1;
                op_r <= (k_r == 2'd3) ? OP_NS : OP_PH;
              end
              OP_D2: op_r <= OP_GL;
              OP_GL: op_r <= OP_JM;
              OP_JM: op_r <= OP_JT;
              OP_JT: op_r <= OP_Y;
              OP_Y:  op_r <= OP_Y2;
              OP_Y2: op_r <= OP_Y3;
              OP_Y3: op_r <= OP_E;
              OP_PM: op_r <= OP_F;
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_ISSUE;
            op_r    <= (op_r == OP_NS) ? OP_D2 : OP_PM;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pitch_r <= in_data.pitch_hz;
      dyn_r   <= in_data.dynamics;
      d_r     <= (in_data.dynamics > pgjm_pkg::DYN_ONE) ? pgjm_pkg::DYN_ONE
                                                        : in_data.dynamics;
      tail_r  <= in_data.tail_mode;
      sum_r   <= '0;
    end
    if (state_r == ST_ISSUE && op_r == OP_T2) begin
      t_r    <= t_cur;
      quad_r <= quad;
    end
    if (mul_done) begin
      case (op_r)
        OP_T2: t2_r    <= prod[32:16];
        OP_U:  u_r     <= pgjm_pkg::POLY_B - prod[31:16];
        OP_V:  v_r     <= pgjm_pkg::POLY_A - {1'b0, prod[31:16]};
        OP_S:  sum_r   <= sum_r + s_term;
        OP_D2: d2_r    <= prod[30:15];
        OP_GL: glide_r <= prod[30:15];
        OP_JM: jm_r    <= prod[29:15];
        OP_JT: cents_r <= 18'(glide_r)
                          + (noise_r[15] ? -18'(jitm) : 18'(jitm));
        OP_Y: begin
          ym_r   <= prod[42:16];
          ysgn_r <= cents_r[17];
        end
        OP_Y2: y2_r  <= prod[56:30];
        OP_Y3: y3m_r <= prod[61:30];
        OP_PM: pm_r  <= prod[39:12];
        OP_F:  freq_r <= (prod[63:54] != 10'd0) ? pgjm_pkg::FREQ_MAX : prod[53:30];
        default: ;
      endcase
    end
    if (div_done) begin
      if (op_r == OP_NS) begin
        noise_r <= sum_r[19] ? -16'(quo[15:0]) : 16'(quo[15:0]);
      end else begin
        e_r <= e_sum[32] ? 32'd0 : e_sum[31:0];
      end
    end
    // result register
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_r.freq_hz   <= freq_r;
      out_r.gain      <= dyn_r;
      out_r.gate_mask <= tail_r ? 6'd0 : (mask_r & gate_en);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier finished outside a multiply step");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside a divide step");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into output register");

endmodule
